[sv/ubxfr_pkg.sv]
// Package with shared types and constants of the UBX frame receiver.
package ubxfr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_CLASS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MSG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS_LENGTH = 3'd4;

  localparam logic [7:0]  FIRST_SYNC_RST     = 8'd181;
  localparam logic [7:0]  SECOND_SYNC_RST    = 8'd98;
  localparam logic [7:0]  POSITION_CLASS_RST = 8'd1;
  localparam logic [7:0]  POSITION_MSG_RST   = 8'd2;
  localparam logic [15:0] MIN_POS_LENGTH_RST = 16'd20;

  localparam logic [15:0] POS_FIRST_BYTE = 16'd4;
  localparam logic [15:0] POS_END_BYTE   = 16'd20;

  typedef struct packed {
    logic [7:0]  first_sync;
    logic [7:0]  second_sync;
    logic [7:0]  position_class;
    logic [7:0]  position_message;
    logic [15:0] min_position_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         frame_class;
    logic [7:0]         frame_message;
    logic [15:0]        frame_length;
    logic               checksum_good;
    logic [7:0]         acked_message;
    logic               position_updated;
    logic signed [31:0] longitude_out;
    logic signed [31:0] latitude_out;
    logic signed [31:0] ellipsoid_height;
    logic signed [31:0] sea_level_height;
  } result_t;

endpackage

[sv/ubxfr_if.sv]
// Channel interfaces for received bytes and finished frame results.
interface ubxfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_class;
  logic [7:0]         frame_message;
  logic [15:0]        frame_length;
  logic               checksum_good;
  logic [7:0]         acked_message;
  logic               position_updated;
  logic signed [31:0] longitude_out;
  logic signed [31:0] latitude_out;
  logic signed [31:0] ellipsoid_height;
  logic signed [31:0] sea_level_height;

  modport source (
    output valid, input ready,
    output frame_class, output frame_message, output frame_length,
    output checksum_good, output acked_message, output position_updated,
    output longitude_out, output latitude_out, output ellipsoid_height,
    output sea_level_height
  );
  modport sink (
    input valid, output ready,
    input frame_class, input frame_message, input frame_length,
    input checksum_good, input acked_message, input position_updated,
    input longitude_out, input latitude_out, input ellipsoid_height,
    input sea_level_height
  );
endinterface

[sv/ubx_frame_receiver.sv]
// Top level of the UBX frame receiver: byte in, one result per finished frame.
// Throughput is one received byte per cycle, stalled only while the final
// checksum byte of a frame waits for the result register to free up.
// A result is offered from the result register after its checksum byte is registered.
// Synchronous active-low reset restores the register defaults, zeroes the
// held position and returns the parser to sync hunting.
module ubx_frame_receiver
  import ubxfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ubxfr_in_if.sink              in_ch,
  ubxfr_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_load;
  logic    res_free;
  logic    in_ready;
  logic    out_valid;

  ubxfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ubxfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_byte  (in_ch.rx_byte),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res)
  );

  ubxfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid;
  assign out_ch.frame_class      = out_res.frame_class;
  assign out_ch.frame_message    = out_res.frame_message;
  assign out_ch.frame_length     = out_res.frame_length;
  assign out_ch.checksum_good    = out_res.checksum_good;
  assign out_ch.acked_message    = out_res.acked_message;
  assign out_ch.position_updated = out_res.position_updated;
  assign out_ch.longitude_out    = out_res.longitude_out;
  assign out_ch.latitude_out     = out_res.latitude_out;
  assign out_ch.ellipsoid_height = out_res.ellipsoid_height;
  assign out_ch.sea_level_height = out_res.sea_level_height;

endmodule

[sv/ubxfr_cfg.sv]
// Configuration register bank of the UBX frame receiver.
module ubxfr_cfg
  import ubxfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_SYNC:     cfg_nxt.first_sync          = cfg_data[7:0];
        CFG_SECOND_SYNC:    cfg_nxt.second_sync         = cfg_data[7:0];
        CFG_POSITION_CLASS: cfg_nxt.position_class      = cfg_data[7:0];
        CFG_POSITION_MSG:   cfg_nxt.position_message    = cfg_data[7:0];
        CFG_MIN_POS_LENGTH: cfg_nxt.min_position_length = cfg_data[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync          <= FIRST_SYNC_RST;
      cfg_r.second_sync         <= SECOND_SYNC_RST;
      cfg_r.position_class      <= POSITION_CLASS_RST;
      cfg_r.position_message    <= POSITION_MSG_RST;
      cfg_r.min_position_length <= MIN_POS_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/ubxfr_parser.sv]
// Input byte register and frame parser with checksum and position capture.
module ubxfr_parser
  import ubxfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       res_free,
  output logic       res_load,
  output result_t    res
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic [3:0]   phase_r, phase_nxt;
  logic [7:0]   class_r, class_nxt;
  logic [7:0]   msg_r, msg_nxt;
  logic [15:0]  len_r, len_nxt;
  logic [15:0]  count_r, count_nxt;
  logic [7:0]   sum_a_r, sum_a_nxt;
  logic [7:0]   sum_b_r, sum_b_nxt;
  logic [7:0]   ck_a_r, ck_a_nxt;
  logic [7:0]   second_r, second_nxt;
  logic [127:0] cap_r, cap_nxt;
  logic [127:0] held_r, held_nxt;

  logic         advance;
  logic         in_fire;
  logic [7:0]   b;
  logic [7:0]   sa_add;
  logic [7:0]   sb_add;
  logic [15:0]  count_inc;
  logic [3:0]   cap_off;
  logic         in_window;
  logic         good;
  logic         upd;
  logic [15:0]  len_full;

  assign b        = s1_byte_r;
  assign advance  = s1_valid_r && ((phase_r != PH_CK_B) || res_free);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign res_load = advance && (phase_r == PH_CK_B);

  assign sa_add    = sum_a_r + b;
  assign sb_add    = sum_b_r + sa_add;
  assign count_inc = count_r + 16'd1;
  assign cap_off   = 4'(count_r - POS_FIRST_BYTE);
  assign in_window = (count_r >= POS_FIRST_BYTE) && (count_r < POS_END_BYTE);
  assign len_full  = {b, len_r[7:0]};

  assign good = (ck_a_r == sum_a_r) && (b == sum_b_r);
  assign upd  = good && (class_r == cfg.position_class) &&
                (msg_r == cfg.position_message) &&
                (len_r >= cfg.min_position_length);

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    msg_nxt    = msg_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    ck_a_nxt   = ck_a_r;
    second_nxt = second_r;
    cap_nxt    = cap_r;
    held_nxt   = held_r;
    if (advance) begin
      case (phase_r)
        PH_SYNC1: begin
          if (b == cfg.first_sync) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_nxt = (b == cfg.second_sync) ? PH_CLASS : PH_SYNC1;
        end
        PH_CLASS: begin
          class_nxt  = b;
          sum_a_nxt  = b;
          sum_b_nxt  = b;
          second_nxt = 8'd0;
          cap_nxt    = '0;
          phase_nxt  = PH_ID;
        end
        PH_ID: begin
          msg_nxt   = b;
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {8'd0, b};
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = len_full;
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          count_nxt = 16'd0;
          phase_nxt = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          if (count_r == 16'd1) begin
            second_nxt = b;
          end
          if (in_window) begin
            cap_nxt[8*cap_off +: 8] = b;
          end
          count_nxt = count_inc;
          if (count_inc >= len_r) begin
            phase_nxt = PH_CK_A;
          end
        end
        PH_CK_A: begin
          ck_a_nxt  = b;
          phase_nxt = PH_CK_B;
        end
        PH_CK_B: begin
          if (upd) begin
            held_nxt = cap_r;
          end
          phase_nxt = PH_SYNC1;
        end
        default: begin
          phase_nxt = PH_SYNC1;
        end
      endcase
    end
  end

  always_comb begin
    res.frame_class      = class_r;
    res.frame_message    = msg_r;
    res.frame_length     = len_r;
    res.checksum_good    = good;
    res.acked_message    = (len_r >= 16'd2) ? second_r : 8'd0;
    res.position_updated = upd;
    res.longitude_out    = held_nxt[31:0];
    res.latitude_out     = held_nxt[63:32];
    res.ellipsoid_height = held_nxt[95:64];
    res.sea_level_height = held_nxt[127:96];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_SYNC1;
      class_r    <= 8'd0;
      msg_r      <= 8'd0;
      len_r      <= 16'd0;
      count_r    <= 16'd0;
      sum_a_r    <= 8'd0;
      sum_b_r    <= 8'd0;
      ck_a_r     <= 8'd0;
      second_r   <= 8'd0;
      cap_r      <= '0;
      held_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      class_r    <= class_nxt;
      msg_r      <= msg_nxt;
      len_r      <= len_nxt;
      count_r    <= count_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      ck_a_r     <= ck_a_nxt;
      second_r   <= second_nxt;
      cap_r      <= cap_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

[sv/ubxfr_out_reg.sv]
// Result register that holds one finished frame until it is taken.
module ubxfr_out_reg
  import ubxfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  output logic    res_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_free  = !valid_r || out_ready;
  assign valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[sv/ubxfr_checker.sv]
// Port-level assertion checker for the UBX frame receiver and its bind.
module ubxfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] frame_length,
  input logic        checksum_good,
  input logic [7:0]  acked_message,
  input logic        position_updated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Receiver not empty after reset.");

  a_update_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !position_updated || checksum_good)
    else $error("Position updated by a frame with a bad checksum.");

  a_short_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (frame_length < 16'd2) |-> acked_message == 8'd0)
    else $error("Acknowledged id nonzero for a short payload.");

endmodule

bind ubx_frame_receiver ubxfr_checker u_ubxfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .frame_length     (out_ch.frame_length),
  .checksum_good    (out_ch.checksum_good),
  .acked_message    (out_ch.acked_message),
  .position_updated (out_ch.position_updated)
);
